// ===== hdl/r5m_pkg.sv =====
// ----------------------------------------------------------------------------
// RAID 5 sector map package
// Shared constants, register indices, layout codes and the configuration
// bundle used by all modules of the sector-to-disk map unit.
// ----------------------------------------------------------------------------
package r5m_pkg;

  localparam int MAX_DISKS_DEF   = 16;
  localparam int SECTOR_BITS_DEF = 48;

  localparam int SECTOR_W    = 48;
  localparam int DISK_W      = 4;
  localparam int CHUNK_W     = 14;
  localparam int LEVEL_W     = 3;
  localparam int MODE_W      = 3;
  localparam int COUNT_W     = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 14;
  localparam int DISK_NW_MAX = 7;

  localparam logic [LEVEL_W-1:0] RAID_LEVEL_4 = 3'd4;
  localparam logic [LEVEL_W-1:0] RAID_LEVEL_5 = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAID_LEVEL    = 3'd0,
    CFG_LAYOUT_MODE   = 3'd1,
    CFG_DISK_COUNT    = 3'd2,
    CFG_CHUNK_SECTORS = 3'd3
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    LAYOUT_LEFT_ASYM  = 3'd0,
    LAYOUT_RIGHT_ASYM = 3'd1,
    LAYOUT_LEFT_SYM   = 3'd2,
    LAYOUT_RIGHT_SYM  = 3'd3,
    LAYOUT_PARITY_0   = 3'd4,
    LAYOUT_PARITY_N   = 3'd5
  } layout_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]     level;
    logic [MODE_W-1:0]      mode;
    logic [DISK_NW_MAX-1:0] n;
    logic [DISK_NW_MAX-1:0] nd;
    logic [CHUNK_W-1:0]     cs;
  } cfg_t;

endpackage

// ===== hdl/raid5_sector_to_disk_map_unit.sv =====
// ----------------------------------------------------------------------------
// RAID 5 sector to disk map unit
// Translates a logical array sector into data disk, parity disk and member
// disk sector for RAID level 4 and the six level 5 layouts.
// ----------------------------------------------------------------------------
// One request enters every cycle while in_stall_o is low, and each passes
// through SECTOR_BITS (at most 48) divider stages, two layout and multiply
// stages and the output register. The latency is set by the bit-per-stage
// divider that splits the sector into chunk, stripe and rotation. The output
// skid stage holds one beat while the consumer stalls; configuration must be
// written while no request is in flight.
module raid5_sector_to_disk_map_unit import r5m_pkg::*; #(
  parameter int MAX_DISKS   = MAX_DISKS_DEF,
  parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SECTOR_W-1:0]   logical_sector_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DISK_W-1:0]     data_disk_o,
  output logic [DISK_W-1:0]     parity_disk_o,
  output logic [SECTOR_W-1:0]   disk_sector_o,
  output logic                  layout_error_o
);

  localparam int LSW = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;
  localparam int NCW = $clog2(MAX_DISKS + 1);
  localparam int NW  = (NCW > DISK_W) ? NCW : DISK_W;
  localparam int PW  = 2 * DISK_W + 1 + LSW;

  cfg_t cfg;
  logic en;

  r5m_cfg #(.MAX_DISKS(MAX_DISKS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic               sv     [LSW+1];
  logic [LSW-1:0]     dvd    [LSW+1];
  logic [CHUNK_W-1:0] rem1   [LSW+1];
  logic [NW-1:0]      rem2   [LSW+1];
  logic [LSW-1:0]     stripe [LSW+1];
  logic [NW-1:0]      rot    [LSW+1];

  assign sv[0]     = in_valid_i;
  assign dvd[0]    = logical_sector_i[LSW-1:0];
  assign rem1[0]   = '0;
  assign rem2[0]   = '0;
  assign stripe[0] = '0;
  assign rot[0]    = '0;

  for (genvar k = 0; k < LSW; k++) begin : g_div
    r5m_div_stage #(.LSW(LSW), .NW(NW)) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .cfg_i    (cfg),
      .valid_i  (sv[k]),
      .dvd_i    (dvd[k]),
      .rem1_i   (rem1[k]),
      .rem2_i   (rem2[k]),
      .stripe_i (stripe[k]),
      .rot_i    (rot[k]),
      .valid_o  (sv[k+1]),
      .dvd_o    (dvd[k+1]),
      .rem1_o   (rem1[k+1]),
      .rem2_o   (rem2[k+1]),
      .stripe_o (stripe[k+1]),
      .rot_o    (rot[k+1])
    );
  end

  logic              t_valid, t_err;
  logic [DISK_W-1:0] t_dd, t_pd;
  logic [LSW-1:0]    t_sec;

  r5m_tail #(.LSW(LSW), .NW(NW)) u_tail (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .cfg_i          (cfg),
    .valid_i        (sv[LSW]),
    .stripe_i       (stripe[LSW]),
    .offs_i         (rem1[LSW]),
    .dd_i           (rem2[LSW]),
    .rot_i          (rot[LSW]),
    .valid_o        (t_valid),
    .data_disk_o    (t_dd),
    .parity_disk_o  (t_pd),
    .disk_sector_o  (t_sec),
    .layout_error_o (t_err)
  );

  logic [PW-1:0] out_data;

  r5m_outbuf #(.PW(PW)) u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_o        (en),
    .valid_i     (t_valid),
    .data_i      ({t_dd, t_pd, t_err, t_sec}),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_data)
  );

  assign in_stall_o     = !en;
  assign data_disk_o    = out_data[PW-1 -: DISK_W];
  assign parity_disk_o  = out_data[PW-DISK_W-1 -: DISK_W];
  assign layout_error_o = out_data[LSW];
  assign disk_sector_o  = SECTOR_W'(out_data[LSW-1:0]);

endmodule

// ===== hdl/r5m_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four array registers and derives the effective disk count,
// data disk count and chunk size used by the datapath.
// ----------------------------------------------------------------------------
module r5m_cfg import r5m_pkg::*; #(
  parameter int MAX_DISKS = MAX_DISKS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [LEVEL_W-1:0] level_q;
  logic [MODE_W-1:0]  mode_q;
  logic [COUNT_W-1:0] count_q;
  logic [CHUNK_W-1:0] chunk_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= RAID_LEVEL_5;
      mode_q  <= LAYOUT_LEFT_SYM;
      count_q <= COUNT_W'(4);
      chunk_q <= CHUNK_W'(128);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RAID_LEVEL:    level_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_LAYOUT_MODE:   mode_q  <= cfg_data_i[MODE_W-1:0];
        CFG_DISK_COUNT:    count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_CHUNK_SECTORS: chunk_q <= cfg_data_i[CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DISK_NW_MAX-1:0] n_eff;

  always_comb begin
    if (count_q < COUNT_W'(3)) begin
      n_eff = DISK_NW_MAX'(3);
    end else if (32'(count_q) > 32'(MAX_DISKS)) begin
      n_eff = DISK_NW_MAX'(MAX_DISKS);
    end else begin
      n_eff = DISK_NW_MAX'(count_q);
    end
  end

  always_comb begin
    cfg_o.level = level_q;
    cfg_o.mode  = mode_q;
    cfg_o.n     = n_eff;
    cfg_o.nd    = n_eff - DISK_NW_MAX'(1);
    cfg_o.cs    = (chunk_q == '0) ? CHUNK_W'(1) : chunk_q;
  end

endmodule

// ===== hdl/r5m_div_stage.sv =====
// ----------------------------------------------------------------------------
// Divider stage
// One bit step of three chained divisions: sector by chunk size, chunk by
// data disk count, and the running stripe residue modulo the disk count.
// ----------------------------------------------------------------------------
module r5m_div_stage import r5m_pkg::*; #(
  parameter int LSW = SECTOR_BITS_DEF,
  parameter int NW  = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cfg_t               cfg_i,
  input  logic               valid_i,
  input  logic [LSW-1:0]     dvd_i,
  input  logic [CHUNK_W-1:0] rem1_i,
  input  logic [NW-1:0]      rem2_i,
  input  logic [LSW-1:0]     stripe_i,
  input  logic [NW-1:0]      rot_i,
  output logic               valid_o,
  output logic [LSW-1:0]     dvd_o,
  output logic [CHUNK_W-1:0] rem1_o,
  output logic [NW-1:0]      rem2_o,
  output logic [LSW-1:0]     stripe_o,
  output logic [NW-1:0]      rot_o
);

  logic [CHUNK_W:0] t1, r1;
  logic [NW:0]      t2, r2, t3, r3;
  logic             q1, q2, q3;
  logic [NW-1:0]    nd, n;

  assign nd = cfg_i.nd[NW-1:0];
  assign n  = cfg_i.n[NW-1:0];

  always_comb begin
    t1 = {rem1_i, dvd_i[LSW-1]};
    q1 = t1 >= {1'b0, cfg_i.cs};
    r1 = q1 ? (t1 - {1'b0, cfg_i.cs}) : t1;
    t2 = {rem2_i, q1};
    q2 = t2 >= {1'b0, nd};
    r2 = q2 ? (t2 - {1'b0, nd}) : t2;
    t3 = {rot_i, q2};
    q3 = t3 >= {1'b0, n};
    r3 = q3 ? (t3 - {1'b0, n}) : t3;
  end

  logic               valid_q;
  logic [LSW-1:0]     dvd_q, stripe_q;
  logic [CHUNK_W-1:0] rem1_q;
  logic [NW-1:0]      rem2_q, rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_q    <= {dvd_i[LSW-2:0], 1'b0};
      rem1_q   <= r1[CHUNK_W-1:0];
      rem2_q   <= r2[NW-1:0];
      stripe_q <= {stripe_i[LSW-2:0], q2};
      rot_q    <= r3[NW-1:0];
    end
  end

  assign valid_o  = valid_q;
  assign dvd_o    = dvd_q;
  assign rem1_o   = rem1_q;
  assign rem2_o   = rem2_q;
  assign stripe_o = stripe_q;
  assign rot_o    = rot_q;

endmodule

// ===== hdl/r5m_tail.sv =====
// ----------------------------------------------------------------------------
// Layout and sector stages
// Places the parity and data disks for the configured level and layout,
// and forms the member disk sector as stripe times chunk size plus offset
// with a split multiply over two register stages.
// ----------------------------------------------------------------------------
module r5m_tail import r5m_pkg::*; #(
  parameter int LSW = SECTOR_BITS_DEF,
  parameter int NW  = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cfg_t               cfg_i,
  input  logic               valid_i,
  input  logic [LSW-1:0]     stripe_i,
  input  logic [CHUNK_W-1:0] offs_i,
  input  logic [NW-1:0]      dd_i,
  input  logic [NW-1:0]      rot_i,
  output logic               valid_o,
  output logic [DISK_W-1:0]  data_disk_o,
  output logic [DISK_W-1:0]  parity_disk_o,
  output logic [LSW-1:0]     disk_sector_o,
  output logic               layout_error_o
);

  localparam int HW = (LSW + 1) / 2;
  localparam int UW = LSW - HW;

  logic [NW:0] n, nd, rot, dd0, pd, dd, s;
  logic        err;

  always_comb begin
    n   = {1'b0, cfg_i.n[NW-1:0]};
    nd  = {1'b0, cfg_i.nd[NW-1:0]};
    rot = {1'b0, rot_i};
    dd0 = {1'b0, dd_i};
    pd  = '0;
    dd  = dd0;
    s   = '0;
    err = 1'b0;
    if (cfg_i.level == RAID_LEVEL_4) begin
      pd = nd;
    end else if (cfg_i.level == RAID_LEVEL_5) begin
      unique case (cfg_i.mode)
        LAYOUT_LEFT_ASYM: begin
          pd = nd - rot;
          dd = (dd0 >= pd) ? dd0 + 1'b1 : dd0;
        end
        LAYOUT_RIGHT_ASYM: begin
          pd = rot;
          dd = (dd0 >= pd) ? dd0 + 1'b1 : dd0;
        end
        LAYOUT_LEFT_SYM: begin
          pd = nd - rot;
          s  = pd + dd0 + 1'b1;
          dd = (s >= n) ? s - n : s;
        end
        LAYOUT_RIGHT_SYM: begin
          pd = rot;
          s  = pd + dd0 + 1'b1;
          dd = (s >= n) ? s - n : s;
        end
        LAYOUT_PARITY_0: begin
          pd = '0;
          dd = dd0 + 1'b1;
        end
        LAYOUT_PARITY_N: begin
          pd = nd;
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end else begin
      err = 1'b1;
    end
  end

  logic                    va_q, vb_q;
  logic [DISK_W-1:0]       dda_q, pda_q, ddb_q, pdb_q;
  logic                    erra_q, errb_q;
  logic [HW+CHUNK_W-1:0]   plo_q;
  logic [UW+CHUNK_W-1:0]   phi_q;
  logic [CHUNK_W-1:0]      offs_q;
  logic [LSW-1:0]          sec_q;
  logic [LSW+CHUNK_W-1:0]  sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  assign sum = {phi_q, {HW{1'b0}}} + (LSW + CHUNK_W)'(plo_q)
             + (LSW + CHUNK_W)'(offs_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dda_q  <= dd[DISK_W-1:0];
      pda_q  <= pd[DISK_W-1:0];
      erra_q <= err;
      plo_q  <= stripe_i[HW-1:0] * cfg_i.cs;
      phi_q  <= stripe_i[LSW-1:HW] * cfg_i.cs;
      offs_q <= offs_i;
      ddb_q  <= dda_q;
      pdb_q  <= pda_q;
      errb_q <= erra_q;
      sec_q  <= sum[LSW-1:0];
    end
  end

  assign valid_o        = vb_q;
  assign data_disk_o    = ddb_q;
  assign parity_disk_o  = pdb_q;
  assign disk_sector_o  = sec_q;
  assign layout_error_o = errb_q;

endmodule

// ===== hdl/r5m_outbuf.sv =====
// ----------------------------------------------------------------------------
// Output register with skid stage
// Presents results to the consumer and catches one beat while the
// consumer stalls, so that the pipeline stops only when both are full.
// ----------------------------------------------------------------------------
module r5m_outbuf import r5m_pkg::*; #(
  parameter int PW = 57
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          en_o,
  input  logic          valid_i,
  input  logic [PW-1:0] data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [PW-1:0] data_o
);

  logic          out_valid_q, full_q;
  logic [PW-1:0] out_q, skid_q;
  logic          take;

  assign en_o = !full_q;
  assign take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      full_q      <= 1'b0;
    end else if (full_q) begin
      if (!out_stall_i) begin
        full_q <= 1'b0;
      end
    end else if (take) begin
      out_valid_q <= valid_i;
    end else if (valid_i) begin
      full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (full_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (take) begin
      out_q <= data_i;
    end else begin
      skid_q <= data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_q;

`ifndef ASSERT_OFF
  a_full_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> out_valid_q) else $error("skid beat held without an output beat");
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !full_q && valid_i) |=> full_q)
    else $error("beat lost while the consumer stalled");
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q && !out_stall_i) |=> (out_valid_q && !full_q))
    else $error("skid beat not moved to the output");
`endif

endmodule
